>>> hw/rtl/olt_pkg.sv
// olt_pkg: shared types and constants of the ordered list table
// no dependencies; used by olt_cell and ordered_list_table
package olt_pkg;

	localparam int DEPTH  = 128;
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int WIDE_W = CNT_W + 9;

	typedef enum logic [2:0] {
		CMD_GET    = 3'd0,
		CMD_LOCATE = 3'd1,
		CMD_INSERT = 3'd2,
		CMD_DELETE = 3'd3,
		CMD_CLEAR  = 3'd4
	} cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] position;
		logic [7:0] value;
	} in_word_t;

	typedef struct packed {
		logic       ok;
		logic [7:0] value_out;
		logic [7:0] found_position;
		logic [7:0] list_length;
	} out_word_t;

	typedef struct packed {
		logic             locate;
		logic             ins;
		logic             del;
		logic [IDX_W-1:0] pos0;
		logic [CNT_W-1:0] count;
		logic [7:0]       val;
	} olt_ctl_t;

	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] pos;
		logic [7:0]       data;
	} olt_tok_t;

endpackage

>>> hw/rtl/olt_cell.sv
// olt_cell: one list entry with its shift and match logic, and one stage of the result chain
// depends on olt_pkg
module olt_cell
	import olt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] idx,
	input  olt_ctl_t         ctl,
	input  logic [7:0]       left,
	input  logic [7:0]       right,
	input  olt_tok_t         tin,
	output logic [7:0]       data,
	output olt_tok_t         tout
);

	logic [7:0]       data_q;
	logic [7:0]       data_d;
	olt_tok_t         tok_q;
	olt_tok_t         tok_d;
	logic [CNT_W-1:0] idx_c;
	logic [CNT_W-1:0] pos_c;
	logic             mine;

	always_comb begin
		idx_c = CNT_W'(idx);
		pos_c = CNT_W'(ctl.pos0);
		if (ctl.locate) begin
			mine = (idx_c < ctl.count) && (data_q == ctl.val);
		end else begin
			mine = (idx == ctl.pos0);
		end
		if (tin.hit || !mine) begin
			tok_d = tin;
		end else begin
			tok_d.hit  = 1'b1;
			tok_d.pos  = idx;
			tok_d.data = data_q;
		end
		data_d = data_q;
		if (ctl.ins) begin
			if (idx_c > pos_c && idx_c <= ctl.count) begin
				data_d = left;
			end else if (idx == ctl.pos0) begin
				data_d = ctl.val;
			end
		end else if (ctl.del) begin
			if (idx_c >= pos_c && (idx_c + CNT_W'(1)) < ctl.count) begin
				data_d = right;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_d;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;
	assign tout = tok_q;

endmodule

>>> hw/rtl/ordered_list_table.sv
// ordered_list_table: ordered list of bytes held in a chain of olt_cell entries
// depends on olt_pkg and olt_cell
//
// Usage: commands arrive on the in channel (in_valid/in_ready/in_data) and
// one result word per command leaves on the out channel (out_valid/out_ready/
// out_data). A command is get, locate, insert, delete or clear.
// After a command is accepted a result token ripples through the chain of
// cells, one cell per cycle, picking up the addressed entry or the first
// match. The result is then loaded into the output register, and insert or
// delete shifts the entries from the addressed position on in the same
// cycle. in_ready rises again in the following cycle, so the block takes a
// new command only after the result of the previous one has been loaded.
// The output register lets a new command enter while the previous result is
// still waiting; if the receiver stalls, the scan holds at its end until the
// output register is free.
// Reset clears the list length and the control state; entry contents are
// left as they are and are never read before being written.
module ordered_list_table
	import olt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data
);

	state_t           state_q;
	state_t           state_d;
	logic [CNT_W-1:0] scan_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	in_word_t         item_q;
	out_word_t        out_q;
	out_word_t        res;
	logic             out_valid_q;
	logic             fin;
	logic             accept;
	olt_ctl_t         ctl;
	olt_tok_t         tok_w [DEPTH+1];
	logic [7:0]       data_w [DEPTH];
	logic [WIDE_W-1:0] pos_w;
	logic [WIDE_W-1:0] cnt_w;
	logic             rd_ok;
	logic             ins_ok;
	logic [7:0]       pos_m1;
	logic [IDX_W:0]   fpos;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign fin      = (state_q == ST_SCAN) && (scan_q == CNT_W'(DEPTH))
		&& (!out_valid_q || out_ready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (fin) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pos_w  = WIDE_W'(item_q.position);
		cnt_w  = WIDE_W'(count_q);
		pos_m1 = item_q.position - 8'd1;
		rd_ok  = (item_q.position != 8'd0) && (pos_w <= cnt_w);
		ins_ok = (item_q.position != 8'd0) && (pos_w <= cnt_w + WIDE_W'(1))
			&& (count_q < CNT_W'(DEPTH));
		fpos   = {1'b0, tok_w[DEPTH].pos} + (IDX_W + 1)'(1);
		res     = '0;
		count_d = count_q;
		ctl.locate = (item_q.cmd == CMD_LOCATE);
		ctl.ins    = 1'b0;
		ctl.del    = 1'b0;
		ctl.pos0   = IDX_W'(pos_m1);
		ctl.count  = count_q;
		ctl.val    = item_q.value;
		case (item_q.cmd)
			CMD_GET: begin
				if (rd_ok) begin
					res.ok        = 1'b1;
					res.value_out = tok_w[DEPTH].data;
				end
			end
			CMD_LOCATE: begin
				if (tok_w[DEPTH].hit) begin
					res.ok             = 1'b1;
					res.found_position = 8'(fpos);
				end
			end
			CMD_INSERT: begin
				if (ins_ok) begin
					res.ok  = 1'b1;
					ctl.ins = fin;
					count_d = count_q + CNT_W'(1);
				end
			end
			CMD_DELETE: begin
				if (rd_ok) begin
					res.ok        = 1'b1;
					res.value_out = tok_w[DEPTH].data;
					ctl.del       = fin;
					count_d       = count_q - CNT_W'(1);
				end
			end
			CMD_CLEAR: begin
				res.ok  = 1'b1;
				count_d = '0;
			end
			default: begin
			end
		endcase
		res.list_length = 8'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			scan_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				scan_q <= '0;
			end else if (state_q == ST_SCAN && scan_q != CNT_W'(DEPTH)) begin
				scan_q <= scan_q + CNT_W'(1);
			end
			if (fin) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_data;
		end
		if (fin) begin
			out_q <= res;
		end
	end

	assign tok_w[0] = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [7:0] left_w;
		logic [7:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = data_w[i];
		end else begin : g_mid_l
			assign left_w = data_w[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_w = data_w[i];
		end else begin : g_mid_r
			assign right_w = data_w[i+1];
		end
		olt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.idx    (IDX_W'(i)),
			.ctl    (ctl),
			.left   (left_w),
			.right  (right_w),
			.tin    (tok_w[i]),
			.data   (data_w[i]),
			.tout   (tok_w[i+1])
		);
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

>>> tb/ordered_list_table_tb.sv
// ordered_list_table_tb: self-checking bench for the ordered list table, with
// random idling on both channels and a cycle-limited run
// depends on olt_pkg and the ordered_list_table rtl
module ordered_list_table_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import olt_pkg::*;

	localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;
	localparam int RANDOM_WORDS = 550;
	localparam int FILL_AT      = 200;
	localparam int LIMIT        = 4 * 700 * (DEPTH + 30);

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_word_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_word_t out_data;

	in_word_t  pending[$];
	out_word_t expected_results[$];

	logic [7:0] list_mem [DEPTH];
	int         list_len;
	int         plan_len;

	logic      in_fired;
	logic      out_fired;
	int        send_gap;
	int        rx_wait;
	int        rx_hold;
	bit        send_calm;
	bit        recv_calm;
	bit        failed;
	int        mismatches;
	int        cycles;
	out_word_t want;

	ordered_list_table DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always #5 clk = ~clk;

	function automatic out_word_t list_apply(in_word_t w);
		out_word_t r;
		int p;
		r = '0;
		p = w.position;
		case (w.cmd)
		CMD_GET: begin
			if (p >= 1 && p <= list_len) begin
				r.ok = 1'b1;
				r.value_out = list_mem[p - 1];
			end
		end
		CMD_LOCATE: begin
			for (int k = 0; k < list_len; k++) begin
				if (list_mem[k] == w.value) begin
					r.ok = 1'b1;
					r.found_position = 8'(k + 1);
					break;
				end
			end
		end
		CMD_INSERT: begin
			if (p >= 1 && p <= list_len + 1 && list_len < DEPTH) begin
				for (int k = list_len; k > p - 1; k--)
					list_mem[k] = list_mem[k - 1];
				list_mem[p - 1] = w.value;
				list_len++;
				r.ok = 1'b1;
			end
		end
		CMD_DELETE: begin
			if (p >= 1 && p <= list_len) begin
				r.value_out = list_mem[p - 1];
				for (int k = p; k < list_len; k++)
					list_mem[k - 1] = list_mem[k];
				list_len--;
				r.ok = 1'b1;
			end
		end
		CMD_CLEAR: begin
			list_len = 0;
			r.ok = 1'b1;
		end
		default: ;
		endcase
		r.list_length = 8'(list_len);
		return r;
	endfunction

	// only the length is tracked while planning, so positions can aim in range
	task automatic queue_word(input logic [2:0] c, input int p, input int v);
		in_word_t w;
		w.cmd = c;
		w.position = 8'(p);
		w.value = 8'(v);
		pending.push_back(w);
		case (c)
		CMD_INSERT: if (p >= 1 && p <= plan_len + 1 && plan_len < DEPTH) plan_len++;
		CMD_DELETE: if (p >= 1 && p <= plan_len) plan_len--;
		CMD_CLEAR: plan_len = 0;
		default: ;
		endcase
	endtask

	function automatic int pick_pos(int hi);
		if (hi < 1 || $urandom_range(0, 9) == 0)
			return $urandom_range(0, 255);
		return $urandom_range(1, hi);
	endfunction

	function automatic int pick_val();
		if ($urandom_range(0, 9) < 6)
			return $urandom_range(0, 15);
		return $urandom_range(0, 255);
	endfunction

	task automatic check_field(input string name, input int exp_v, input int got_v);
		if (exp_v != got_v) begin
			failed = 1'b1;
			mismatches++;
			if (mismatches <= 60)
				$error("%s expected %0d actual %0d", name, exp_v, got_v);
		end
	endtask

	task automatic plan_directed();
		queue_word(CMD_CLEAR, 0, 0);
		queue_word(CMD_GET, 1, 0);
		queue_word(CMD_DELETE, 1, 0);
		queue_word(CMD_LOCATE, 0, 8'h00);
		queue_word(CMD_INSERT, 0, 8'h11);
		queue_word(CMD_INSERT, 2, 8'h11);
		queue_word(CMD_INSERT, 1, 8'h00);
		queue_word(CMD_INSERT, 2, 8'hff);
		queue_word(CMD_INSERT, 1, 8'ha5);
		queue_word(CMD_INSERT, 4, 8'ha5);
		queue_word(CMD_INSERT, 3, 8'h3c);
		queue_word(CMD_LOCATE, 0, 8'ha5);
		queue_word(CMD_LOCATE, 255, 8'hff);
		queue_word(CMD_LOCATE, 0, 8'h77);
		queue_word(CMD_GET, 0, 0);
		queue_word(CMD_GET, 5, 0);
		queue_word(CMD_GET, 6, 0);
		queue_word(CMD_GET, 255, 8'hff);
		queue_word(CMD_DELETE, 2, 0);
		queue_word(CMD_DELETE, 0, 0);
		queue_word(CMD_DELETE, 255, 0);
		for (int c = CMD_UNUSED_FIRST; c <= CMD_UNUSED_LAST; c++)
			queue_word(3'(c), 255, 8'hff);
		queue_word(CMD_CLEAR, 255, 8'hff);
		queue_word(CMD_GET, 1, 0);
	endtask

	task automatic plan_random();
		int n;
		int r;
		n = 0;
		while (n < RANDOM_WORDS) begin
			if (n == FILL_AT) begin
				// fill to the brim, then push against the full list
				while (plan_len < DEPTH) begin
					queue_word(CMD_INSERT, $urandom_range(1, plan_len + 1), pick_val());
					n++;
				end
				queue_word(CMD_INSERT, DEPTH + 1, pick_val());
				queue_word(CMD_INSERT, 1, pick_val());
				queue_word(CMD_LOCATE, 0, pick_val());
				queue_word(CMD_GET, DEPTH, 0);
				queue_word(CMD_GET, DEPTH + 1, 0);
				queue_word(CMD_DELETE, DEPTH, 0);
				queue_word(CMD_INSERT, DEPTH, pick_val());
				queue_word(CMD_DELETE, 1, 0);
				n += 8;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 5)
					queue_word(3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST)),
						$urandom_range(0, 255), $urandom_range(0, 255));
				else if (r < 8)
					queue_word(CMD_CLEAR, $urandom_range(0, 255), $urandom_range(0, 255));
				else if (r < 38)
					queue_word(CMD_INSERT, pick_pos(plan_len + 1), pick_val());
				else if (r < 60)
					queue_word(CMD_DELETE, pick_pos(plan_len), $urandom_range(0, 255));
				else if (r < 80)
					queue_word(CMD_GET, pick_pos(plan_len), $urandom_range(0, 255));
				else
					queue_word(CMD_LOCATE, $urandom_range(0, 255), pick_val());
				n++;
			end
		end
	endtask

	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_fired) begin
				// hold the word until taken
			end else if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending.size() > 0) begin
				if ($urandom_range(0, 29) == 0)
					send_calm = !send_calm;
				in_data <= pending.pop_front();
				in_valid <= 1'b1;
				send_gap <= send_calm ? 0 : $urandom_range(0, 10);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (out_fired) begin
				if ($urandom_range(0, 29) == 0)
					recv_calm = !recv_calm;
				rx_hold = recv_calm ? 0 : $urandom_range(0, 10);
				out_ready <= (rx_hold == 0);
				rx_wait <= rx_hold;
			end else if (out_valid && !out_ready) begin
				if (rx_wait > 0)
					rx_wait <= rx_wait - 1;
				else
					out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			in_fired <= in_valid && in_ready;
			out_fired <= out_valid && out_ready;
			if (in_valid && in_ready)
				expected_results.push_back(list_apply(in_data));
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					failed = 1'b1;
					mismatches++;
					if (mismatches <= 60)
						$error("result word with nothing outstanding");
				end else begin
					want = expected_results.pop_front();
					check_field("ok", want.ok, out_data.ok);
					check_field("value_out", want.value_out, out_data.value_out);
					check_field("found_position", want.found_position,
						out_data.found_position);
					check_field("list_length", want.list_length, out_data.list_length);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		in_fired = 1'b0;
		out_fired = 1'b0;
		send_gap = 0;
		rx_wait = 0;
		send_calm = 1'b0;
		recv_calm = 1'b0;
		failed = 1'b0;
		mismatches = 0;
		cycles = 0;
		list_len = 0;
		plan_len = 0;
		plan_directed();
		plan_random();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		do
			@(posedge clk);
		while (pending.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (DEPTH + 20) @(posedge clk);
		if (!failed)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
